/* rtl/core/ccd_pkg.sv */
package ccd_pkg;

    localparam int DEF_MAX_COLUMNS    = 128;
    localparam int DEF_MAX_ROWS       = 64;
    localparam int DEF_DIST_TOLERANCE = 7;

    localparam int IN_DATA_W   = 56;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 1;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam int CW          = 14;
    localparam int DXW         = 10;
    localparam int SW          = 20;
    localparam int CNT_W       = 14;
    localparam int GLYPH_W     = 16;
    localparam int PAINT_W     = 8;
    localparam int CELL_W      = GLYPH_W + PAINT_W;

    localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 16'h0020;
    localparam logic [CNT_W-1:0]   COUNT_MAX   = 14'h3FFF;
    localparam logic [7:0]         RESET_WIDTH  = 8'd80;
    localparam logic [6:0]         RESET_HEIGHT = 7'd25;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_PUT     = 2'd0;
    localparam t_cmd CMD_SOLID   = 2'd1;
    localparam t_cmd CMD_OUTLINE = 2'd2;
    localparam t_cmd CMD_READ    = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

endpackage

/* rtl/core/clipped_circle_cell_drawer.sv */
// Character-cell screen store of MAX_COLUMNS x MAX_ROWS cells (16-bit glyph, 8-bit paint)
// with a circle drawing engine, one result item for every command item. After reset the
// block sweeps the cell memory once, one cell per cycle, writing the space glyph with
// paint 0; no item is accepted until the sweep is done, while the two configuration
// registers can be written. A put command and a read of an off-screen cell pass through
// the command and done states; a read of an on-screen cell also waits in a state for the
// registered read data of the cell memory.
// A circle command scans every cell of its bounding square, (2 * radius + 1) squared at
// most, that remains on screen after clipping: the single write port of the cell memory
// handles one cell per cycle. A finished result waits in the output register while the
// next item is accepted; a command that finishes while that register is still full
// holds in its done state until the result is taken.
module clipped_circle_cell_drawer #(
    parameter int MAX_COLUMNS    = ccd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS       = ccd_pkg::DEF_MAX_ROWS,
    parameter int DIST_TOLERANCE = ccd_pkg::DEF_DIST_TOLERANCE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x[11:0], pos_y[23:12], radius[31:24], glyph[47:32], paint[55:48]
    input  logic [ccd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  logic [ccd_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_glyph[15:0], read_paint[23:16], cells_written[37:24], zero[39:38]
    output logic [ccd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // in_bounds[0]
    output logic [ccd_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ccd_pkg::APB_AW-1:0]      paddr,
    input  logic [ccd_pkg::APB_DW-1:0]      pwdata,
    output logic [ccd_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import ccd_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0]        COLS_A   = AW'(MAX_COLUMNS);
    localparam logic [AW-1:0]        LAST_A   = AW'(DEPTH - 1);
    localparam logic signed [CW-1:0] COLS_C   = CW'(MAX_COLUMNS);
    localparam logic signed [CW-1:0] ROWS_C   = CW'(MAX_ROWS);
    localparam logic signed [SW-1:0] TOL_S    = SW'(DIST_TOLERANCE);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_CMD   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_RDATA = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_mem_q;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [CELL_W-1:0] mem_wdata;

    logic [2:0]              r_state, n_state;
    logic [7:0]              r_width, n_width;
    logic [6:0]              r_height, n_height;
    t_cmd                    r_cmd, n_cmd;
    logic signed [CW-1:0]    r_px, n_px, r_py, n_py;
    logic [7:0]              r_rad, n_rad;
    logic [GLYPH_W-1:0]      r_glyph, n_glyph;
    logic [PAINT_W-1:0]      r_paint, n_paint;
    logic signed [CW-1:0]    r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    logic signed [CW-1:0]    r_x, n_x, r_y, n_y;
    logic signed [DXW-1:0]   r_dx, n_dx, r_dx0, n_dx0, r_dy, n_dy;
    logic signed [SW-1:0]    r_dx2, n_dx2, r_dx0sq, n_dx0sq, r_dy2, n_dy2;
    logic signed [SW-1:0]    r_lim_lo, n_lim_lo, r_lim_hi, n_lim_hi;
    logic [AW-1:0]           r_addr, n_addr, r_row_step, n_row_step;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [GLYPH_W-1:0]      r_res_glyph, n_res_glyph;
    logic [PAINT_W-1:0]      r_res_paint, n_res_paint;
    logic                    r_res_inb, n_res_inb;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;
    logic                    r_out_inb, n_out_inb;

    logic signed [CW-1:0]    vis_w, vis_h;
    logic                    on_screen;
    logic [AW-1:0]           cell_addr;
    logic signed [CW-1:0]    x_lo, x_hi, y_lo, y_hi;
    logic signed [CW-1:0]    dx0_w, dy0_w;
    logic signed [DXW-1:0]   dx0_n, dy0_n;
    logic signed [2*DXW-1:0] sq_x, sq_y;
    logic [15:0]             r2;
    logic signed [SW-1:0]    r2_s;
    logic signed [SW-1:0]    d2, step_x, step_y;
    logic                    hit;
    logic                    cfg_wr;

    always_comb begin
        vis_w = ($signed({{(CW-8){1'b0}}, r_width}) > COLS_C) ? COLS_C
              : $signed({{(CW-8){1'b0}}, r_width});
        vis_h = ($signed({{(CW-7){1'b0}}, r_height}) > ROWS_C) ? ROWS_C
              : $signed({{(CW-7){1'b0}}, r_height});
        on_screen = (r_px >= 0) && (r_px < vis_w) && (r_py >= 0) && (r_py < vis_h);
        cell_addr = AW'(r_py) * COLS_A + AW'(r_px);

        x_lo = r_px - $signed({{(CW-8){1'b0}}, r_rad});
        x_hi = r_px + $signed({{(CW-8){1'b0}}, r_rad});
        y_lo = r_py - $signed({{(CW-8){1'b0}}, r_rad});
        y_hi = r_py + $signed({{(CW-8){1'b0}}, r_rad});

        dx0_w = r_x0 - r_px;
        dy0_w = r_y0 - r_py;
        dx0_n = dx0_w[DXW-1:0];
        dy0_n = dy0_w[DXW-1:0];
        sq_x  = dx0_n * dx0_n;
        sq_y  = dy0_n * dy0_n;
        r2    = r_rad * r_rad;
        r2_s  = $signed({{(SW-16){1'b0}}, r2});

        d2     = r_dx2 + r_dy2;
        hit    = (d2 < r_lim_hi) && ((r_cmd == CMD_SOLID) || (d2 > r_lim_lo));
        step_x = $signed({{(SW-DXW-1){r_dx[DXW-1]}}, r_dx, 1'b1});
        step_y = $signed({{(SW-DXW-1){r_dy[DXW-1]}}, r_dy, 1'b1});
    end

    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_HEIGHT) ? {{(APB_DW-7){1'b0}}, r_height}
                                                    : {{(APB_DW-8){1'b0}}, r_width};
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_inb;

    always_comb begin
        n_state     = r_state;
        n_width     = r_width;
        n_height    = r_height;
        n_cmd       = r_cmd;
        n_px        = r_px;
        n_py        = r_py;
        n_rad       = r_rad;
        n_glyph     = r_glyph;
        n_paint     = r_paint;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_y0        = r_y0;
        n_y1        = r_y1;
        n_x         = r_x;
        n_y         = r_y;
        n_dx        = r_dx;
        n_dx0       = r_dx0;
        n_dy        = r_dy;
        n_dx2       = r_dx2;
        n_dx0sq     = r_dx0sq;
        n_dy2       = r_dy2;
        n_lim_lo    = r_lim_lo;
        n_lim_hi    = r_lim_hi;
        n_addr      = r_addr;
        n_row_step  = r_row_step;
        n_cnt       = r_cnt;
        n_res_glyph = r_res_glyph;
        n_res_paint = r_res_paint;
        n_res_inb   = r_res_inb;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_inb   = r_out_inb;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_addr;
        mem_wdata   = {r_paint, SPACE_GLYPH};

        if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                n_height = pwdata[6:0];
            end else begin
                n_width = pwdata[7:0];
            end
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = {{PAINT_W{1'b0}}, SPACE_GLYPH};
                n_addr    = r_addr + AW'(1);
                if (r_addr == LAST_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser[1:0];
                    n_px    = {{(CW-12){s_axis_tdata[11]}}, s_axis_tdata[11:0]};
                    n_py    = {{(CW-12){s_axis_tdata[23]}}, s_axis_tdata[23:12]};
                    n_rad   = s_axis_tdata[31:24];
                    n_glyph = s_axis_tdata[47:32];
                    n_paint = s_axis_tdata[55:48];
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                n_res_glyph = '0;
                n_res_paint = '0;
                n_res_inb   = 1'b0;
                n_cnt       = '0;
                n_x0        = (x_lo < 0) ? '0 : x_lo;
                n_x1        = (x_hi > vis_w - CW'(1)) ? vis_w - CW'(1) : x_hi;
                n_y0        = (y_lo < 0) ? '0 : y_lo;
                n_y1        = (y_hi > vis_h - CW'(1)) ? vis_h - CW'(1) : y_hi;
                n_state     = S_DONE;
                case (r_cmd)
                    CMD_PUT: begin
                        if (on_screen) begin
                            mem_we    = 1'b1;
                            mem_addr  = cell_addr;
                            mem_wdata = {r_paint, r_glyph};
                            n_res_inb = 1'b1;
                            n_cnt     = CNT_W'(1);
                        end
                    end
                    CMD_READ: begin
                        if (on_screen) begin
                            mem_re    = 1'b1;
                            mem_addr  = cell_addr;
                            n_res_inb = 1'b1;
                            n_state   = S_RDATA;
                        end
                    end
                    default: begin
                        n_state = S_SQ;
                    end
                endcase
            end
            S_SQ: begin
                if ((r_x0 > r_x1) || (r_y0 > r_y1)) begin
                    n_state = S_DONE;
                end else begin
                    n_x        = r_x0;
                    n_y        = r_y0;
                    n_dx       = dx0_n;
                    n_dx0      = dx0_n;
                    n_dy       = dy0_n;
                    n_dx2      = SW'(sq_x);
                    n_dx0sq    = SW'(sq_x);
                    n_dy2      = SW'(sq_y);
                    n_lim_hi   = r2_s + TOL_S;
                    n_lim_lo   = r2_s - TOL_S;
                    n_addr     = AW'(r_y0) * COLS_A + AW'(r_x0);
                    n_row_step = COLS_A - AW'(r_x1 - r_x0);
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    mem_we = 1'b1;
                    if (r_cnt != COUNT_MAX) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                if (r_x == r_x1) begin
                    if (r_y == r_y1) begin
                        n_state = S_DONE;
                    end else begin
                        n_y    = r_y + CW'(1);
                        n_dy   = r_dy + DXW'(1);
                        n_dy2  = r_dy2 + step_y;
                        n_x    = r_x0;
                        n_dx   = r_dx0;
                        n_dx2  = r_dx0sq;
                        n_addr = r_addr + r_row_step;
                    end
                end else begin
                    n_x    = r_x + CW'(1);
                    n_dx   = r_dx + DXW'(1);
                    n_dx2  = r_dx2 + step_x;
                    n_addr = r_addr + AW'(1);
                end
            end
            S_RDATA: begin
                n_res_glyph = r_mem_q[GLYPH_W-1:0];
                n_res_paint = r_mem_q[CELL_W-1:GLYPH_W];
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(OUT_DATA_W-CNT_W-CELL_W){1'b0}}, r_cnt,
                                   r_res_paint, r_res_glyph};
                    n_out_inb   = r_res_inb;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_width     <= RESET_WIDTH;
            r_height    <= RESET_HEIGHT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_width     <= n_width;
            r_height    <= n_height;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_px        <= n_px;
        r_py        <= n_py;
        r_rad       <= n_rad;
        r_glyph     <= n_glyph;
        r_paint     <= n_paint;
        r_x0        <= n_x0;
        r_x1        <= n_x1;
        r_y0        <= n_y0;
        r_y1        <= n_y1;
        r_x         <= n_x;
        r_y         <= n_y;
        r_dx        <= n_dx;
        r_dx0       <= n_dx0;
        r_dy        <= n_dy;
        r_dx2       <= n_dx2;
        r_dx0sq     <= n_dx0sq;
        r_dy2       <= n_dy2;
        r_lim_lo    <= n_lim_lo;
        r_lim_hi    <= n_lim_hi;
        r_row_step  <= n_row_step;
        r_cnt       <= n_cnt;
        r_res_glyph <= n_res_glyph;
        r_res_paint <= n_res_paint;
        r_res_inb   <= n_res_inb;
        r_out_data  <= n_out_data;
        r_out_inb   <= n_out_inb;
    end

endmodule

/* dv/clipped_circle_cell_drawer_test.sv */
module clipped_circle_cell_drawer_test;
    import ccd_pkg::*;

    localparam int QUIET_LIMIT = 40000;
    localparam int CELL_COUNT  = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

    typedef struct {
        logic [GLYPH_W-1:0] glyph;
        logic [PAINT_W-1:0] paint;
        logic               in_bounds;
        logic [CNT_W-1:0]   cells;
    } t_cell_report;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_PATTERN} t_ready_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    logic [GLYPH_W-1:0] glyph_mirror [CELL_COUNT];
    logic [PAINT_W-1:0] paint_mirror [CELL_COUNT];
    int                 screen_cols = RESET_WIDTH;
    int                 screen_rows = RESET_HEIGHT;

    t_cell_report pending_reports[$];
    t_cell_report want_report;

    int failures = 0;
    int items_sent = 0;
    int cmd_seen[4] = '{0, 0, 0, 0};
    int sizes_tried = 1;
    int cells_painted = 0;
    int quiet_cycles = 0;
    int hold_cycles_left = 0;
    bit sender_bursty = 1'b1;
    int burst_left = 0;

    clipped_circle_cell_drawer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int visible_cols();
        return (screen_cols < DEF_MAX_COLUMNS) ? screen_cols : DEF_MAX_COLUMNS;
    endfunction

    function automatic int visible_rows();
        return (screen_rows < DEF_MAX_ROWS) ? screen_rows : DEF_MAX_ROWS;
    endfunction

    // Applies one command to the mirrored screen and returns the report it should produce.
    function automatic t_cell_report apply_command(t_cmd op, int px, int py, int radius,
                                                   logic [GLYPH_W-1:0] glyph,
                                                   logic [PAINT_W-1:0] paint);
        t_cell_report rep;
        int cols, rows, r2, x_lo, x_hi, y_lo, y_hi, d2, diff, count;
        logic hit;
        rep = '{glyph: '0, paint: '0, in_bounds: 1'b0, cells: '0};
        cols = visible_cols();
        rows = visible_rows();
        count = 0;
        if (op == CMD_PUT || op == CMD_READ) begin
            if (px >= 0 && px < cols && py >= 0 && py < rows) begin
                rep.in_bounds = 1'b1;
                if (op == CMD_PUT) begin
                    glyph_mirror[py * DEF_MAX_COLUMNS + px] = glyph;
                    paint_mirror[py * DEF_MAX_COLUMNS + px] = paint;
                    count = 1;
                end else begin
                    rep.glyph = glyph_mirror[py * DEF_MAX_COLUMNS + px];
                    rep.paint = paint_mirror[py * DEF_MAX_COLUMNS + px];
                end
            end
        end else begin
            r2 = radius * radius;
            x_lo = (px - radius < 0) ? 0 : px - radius;
            y_lo = (py - radius < 0) ? 0 : py - radius;
            x_hi = (px + radius > cols - 1) ? cols - 1 : px + radius;
            y_hi = (py + radius > rows - 1) ? rows - 1 : py + radius;
            for (int y = y_lo; y <= y_hi; y++) begin
                for (int x = x_lo; x <= x_hi; x++) begin
                    d2 = (x - px) * (x - px) + (y - py) * (y - py);
                    diff = d2 - r2;
                    if (op == CMD_SOLID) begin
                        hit = d2 < r2 + DEF_DIST_TOLERANCE;
                    end else begin
                        hit = ((diff < 0) ? -diff : diff) < DEF_DIST_TOLERANCE;
                    end
                    if (hit) begin
                        glyph_mirror[y * DEF_MAX_COLUMNS + x] = SPACE_GLYPH;
                        paint_mirror[y * DEF_MAX_COLUMNS + x] = paint;
                        if (count < COUNT_MAX) begin
                            count++;
                        end
                    end
                end
            end
        end
        rep.cells = count[CNT_W-1:0];
        cells_painted += count;
        return rep;
    endfunction

    function automatic int near_coord(int extent);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 4095)) - 2048;
            1: return extent - 2 + int'($urandom_range(0, 2));
            default: return int'($urandom_range(0, extent + 3)) - 2;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    task automatic send_command(input t_cmd op, input int px, input int py, input int radius,
                                input int glyph, input int paint);
        logic signed [11:0] x_bits;
        logic signed [11:0] y_bits;
        x_bits = px[11:0];
        y_bits = py[11:0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {paint[7:0], glyph[15:0], radius[7:0], y_bits, x_bits};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_reports.push_back(apply_command(op, int'(x_bits), int'(y_bits), radius[7:0],
                                                glyph[15:0], paint[7:0]));
        cmd_seen[op]++;
        items_sent++;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 60)
                                                    : $urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (index == REG_WIDTH) begin
            screen_cols = value[7:0];
        end else begin
            screen_rows = value[6:0];
        end
    endtask

    task automatic set_screen(input int cols, input int rows);
        wait_for_reports();
        write_register(REG_WIDTH, cols);
        write_register(REG_HEIGHT, rows);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sizes_tried++;
    endtask

    // Mostly a single random command, else a put followed by a read of the same cell,
    // or a circle followed by a read near its center.
    task automatic send_random_sequence();
        int px, py, glyph, paint, radius, pick;
        px = near_coord(visible_cols());
        py = near_coord(visible_rows());
        glyph = $urandom_range(0, 65535);
        paint = $urandom_range(0, 255);
        pick = $urandom_range(0, 99);
        radius = (pick < 70) ? $urandom_range(0, 6) :
                 (pick < 95) ? $urandom_range(7, 20) :
                 (pick < 98) ? $urandom_range(21, 70) : $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            6, 7, 8: begin
                send_command(CMD_PUT, px, py, radius, glyph, paint);
                send_command(CMD_READ, px, py, $urandom_range(0, 255),
                             $urandom_range(0, 65535), $urandom_range(0, 255));
            end
            9: begin
                send_command($urandom_range(0, 1) ? CMD_SOLID : CMD_OUTLINE,
                             px, py, radius, glyph, paint);
                send_command(CMD_READ, px + int'($urandom_range(0, 4)) - 2, py, 0, 0, 0);
            end
            default: begin
                send_command(t_cmd'($urandom_range(0, 3)), px, py, radius, glyph, paint);
            end
        endcase
    endtask

    task automatic test_cell_access();
        send_command(CMD_PUT, 0, 0, 0, 16'hFFFF, 8'hFF);
        send_command(CMD_READ, 0, 0, 0, 0, 0);
        send_command(CMD_PUT, 79, 24, 255, 16'h0000, 8'h00);
        send_command(CMD_READ, 79, 24, 0, 0, 0);
        send_command(CMD_PUT, 80, 0, 0, 16'h1234, 8'h56);
        send_command(CMD_PUT, 0, 25, 0, 16'h1234, 8'h56);
        send_command(CMD_PUT, -1, 5, 0, 16'hABCD, 8'h11);
        send_command(CMD_PUT, 2047, -2048, 0, 16'h5555, 8'hAA);
        send_command(CMD_READ, -2048, 2047, 0, 16'hFFFF, 8'hFF);
        send_command(CMD_READ, 80, 24, 0, 0, 0);
        send_command(CMD_READ, 10, 10, 0, 0, 0);
        send_command(CMD_PUT, 10, 10, 0, 16'h0020, 8'h00);
    endtask

    task automatic test_circle_shapes();
        send_command(CMD_SOLID, 40, 12, 0, 0, 8'h01);
        send_command(CMD_OUTLINE, 20, 12, 0, 0, 8'h02);
        send_command(CMD_SOLID, 0, 0, 1, 0, 8'h03);
        send_command(CMD_OUTLINE, 79, 24, 5, 0, 8'h04);
        send_command(CMD_OUTLINE, 40, 12, 16, 0, 8'h05);
        send_command(CMD_SOLID, -2048, -2048, 255, 0, 8'h06);
        send_command(CMD_OUTLINE, 40, 12, 255, 0, 8'h07);
        send_command(CMD_SOLID, 40, 12, 255, 0, 8'hFF);
        send_command(CMD_READ, 0, 0, 0, 0, 0);
        send_command(CMD_READ, 79, 24, 0, 0, 0);
    endtask

    task automatic test_screen_sizes();
        int cols_list[7] = '{0, 30, 1, 128, 255, 7, 129};
        int rows_list[7] = '{25, 0, 1, 64, 127, 3, 65};
        int stop_at;
        for (int i = 0; i < 7; i++) begin
            set_screen(cols_list[i], rows_list[i]);
            stop_at = items_sent + 16;
            while (items_sent < stop_at) send_random_sequence();
        end
    endtask

    task automatic test_random_traffic();
        int stop_at;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_screen(RESET_WIDTH, RESET_HEIGHT);
                1: set_screen($urandom_range(1, 128), $urandom_range(1, 64));
                2: set_screen(40, 16);
                default: set_screen($urandom_range(0, 255), $urandom_range(0, 127));
            endcase
            sender_bursty = (phase != 2);
            stop_at = items_sent + 100;
            while (items_sent < stop_at) send_random_sequence();
        end
        sender_bursty = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_for_reports();
        sender_bursty = 1'b0;
        hold_cycles_left = 400;
        for (int i = 0; i < 24; i++) begin
            send_command(t_cmd'($urandom_range(0, 3)), near_coord(visible_cols()),
                         near_coord(visible_rows()), $urandom_range(0, 3),
                         $urandom_range(0, 65535), $urandom_range(0, 255));
        end
        wait_for_reports();
        sender_bursty = 1'b1;
    endtask

    initial begin : receiver
        t_ready_style style;
        int style_left;
        int tick;
        style = READY_ALWAYS;
        style_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles_left--;
            end else begin
                if (style_left == 0) begin
                    style = t_ready_style'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                tick++;
                case (style)
                    READY_ALWAYS: m_axis_tready <= 1'b1;
                    READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    READY_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default:      m_axis_tready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $error("Result item arrived with no command outstanding");
                failures++;
            end else begin
                want_report = pending_reports.pop_front();
                check_field("read_glyph", want_report.glyph, m_axis_tdata[15:0]);
                check_field("read_paint", want_report.paint, m_axis_tdata[23:16]);
                check_field("cells_written", want_report.cells, m_axis_tdata[37:24]);
                check_field("in_bounds", want_report.in_bounds, m_axis_tuser[0]);
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < CELL_COUNT; i++) begin
            glyph_mirror[i] = SPACE_GLYPH;
            paint_mirror[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_cell_access();
        test_circle_shapes();
        test_screen_sizes();
        test_random_traffic();
        test_backpressure();
        wait_for_reports();
        repeat (40) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $error("%0d results never arrived", pending_reports.size());
            failures++;
        end
        $display("Ran %0d commands: %0d puts, %0d solid, %0d outline, %0d reads;",
                 items_sent, cmd_seen[CMD_PUT], cmd_seen[CMD_SOLID], cmd_seen[CMD_OUTLINE],
                 cmd_seen[CMD_READ]);
        $display("%0d cells painted over %0d screen sizes, including zero and oversized, %s",
                 cells_painted, sizes_tried, "with long back-pressure.");
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/ccd_pkg.sv
rtl/core/clipped_circle_cell_drawer.sv
dv/clipped_circle_cell_drawer_test.sv
